@@ src/b64e_pkg.sv @@
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// No dependencies.
`default_nettype none

package b64e_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CharW  = 7;
    localparam int unsigned GroupW = 3 * ByteW;
    localparam int unsigned SextW  = 6;

    // ASCII codes used by the alphabet mapping
    localparam logic [CharW-1:0] CharPad   = 7'd61;  // '='
    localparam logic [CharW-1:0] CharPlus  = 7'd43;  // '+'
    localparam logic [CharW-1:0] CharSlash = 7'd47;  // '/'
    localparam logic [CharW-1:0] CharUpA   = 7'd65;  // 'A'
    localparam logic [CharW-1:0] LowOffset = 7'd71;  // 'a' - 26
    localparam logic [CharW-1:0] DigOffset = 7'd4;   // 52 - '0'

    // character counts of a group (remaining slots are padding)
    localparam logic [2:0] NChars1Byte = 3'd2;
    localparam logic [2:0] NChars2Byte = 3'd3;
    localparam logic [2:0] NCharsFull  = 3'd4;

    // one group handed from front to back
    typedef struct packed {
        logic [GroupW-1:0] triple;   // first byte in the top bits
        logic [2:0]        n_chars;  // 2..4 real characters
        logic              final_grp; // group closes the message
    } group_t;

    // 6-bit index to standard-alphabet ASCII
    function automatic logic [CharW-1:0] b64e_char(input logic [SextW-1:0] idx);
        logic [CharW-1:0] idx_w;
        logic [CharW-1:0] ch;
        idx_w = {1'b0, idx};
        priority if (idx < 6'd26) begin
            ch = CharUpA + idx_w;
        end else if (idx < 6'd52) begin
            ch = LowOffset + idx_w;
        end else if (idx < 6'd62) begin
            ch = idx_w - DigOffset;
        end else if (idx == 6'd62) begin
            ch = CharPlus;
        end else begin
            ch = CharSlash;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ src/b64e_front.sv @@
// Front end: accepts byte beats, buffers up to two bytes, forms groups.
// Depends on b64e_pkg.
`default_nettype none

module b64e_front import b64e_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [ByteW-1:0] s_data_byte,
    input  wire logic             s_is_last,
    output logic                  q_push,
    output group_t                q_data,
    input  wire logic             q_ready
);

    logic [2*ByteW-1:0] pending_reg, pending_next;
    logic [1:0]         count_reg, count_next;
    logic               accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    // classify the beat: buffer it or close a group
    always_comb begin
        pending_next = pending_reg;
        count_next   = count_reg;
        q_push       = 1'b0;
        q_data       = '{triple: '0, n_chars: NCharsFull, final_grp: s_is_last};
        if (accept) begin
            unique case (count_reg)
                2'd0: begin
                    if (!s_is_last) begin
                        pending_next[2*ByteW-1:ByteW] = s_data_byte;
                        count_next = 2'd1;
                    end else begin
                        q_push         = 1'b1;
                        q_data.triple  = {s_data_byte, {(2*ByteW){1'b0}}};
                        q_data.n_chars = NChars1Byte;
                    end
                end
                2'd1: begin
                    if (!s_is_last) begin
                        pending_next[ByteW-1:0] = s_data_byte;
                        count_next = 2'd2;
                    end else begin
                        q_push         = 1'b1;
                        q_data.triple  = {pending_reg[2*ByteW-1:ByteW], s_data_byte,
                                          {ByteW{1'b0}}};
                        q_data.n_chars = NChars2Byte;
                    end
                end
                default: begin
                    // full group (a count of 3 behaves as 2)
                    q_push         = 1'b1;
                    q_data.triple  = {pending_reg, s_data_byte};
                    q_data.n_chars = NCharsFull;
                end
            endcase
            if (q_push) begin
                pending_next = '0;
                count_next   = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            count_reg   <= 2'd0;
        end else begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/b64e_queue.sv @@
// Two-entry group queue between front and back.
// Depends on b64e_pkg.
`default_nettype none

module b64e_queue import b64e_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire group_t push_data,
    output logic        push_ready,
    input  wire logic   pop,
    output group_t      pop_data,
    output logic        pop_valid
);

    group_t     entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/b64e_back.sv @@
// Back end: serializes one group into four characters, one per cycle unless
// m_ready stalls, through a registered output stage. Depends on b64e_pkg.
`default_nettype none

module b64e_back import b64e_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    input  wire group_t           q_data,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [CharW-1:0]      m_out_char,
    output logic                  m_last_char
);

    group_t           group_reg, group_next;
    logic [1:0]       slot_reg, slot_next;
    logic             busy_reg, busy_next;
    logic             valid_reg, valid_next;
    logic [CharW-1:0] char_reg, char_next;
    logic             last_reg, last_next;
    logic             advance;
    logic [SextW-1:0] sext;
    logic             is_pad;

    assign advance = busy_reg && (!valid_reg || m_ready);
    assign q_pop   = q_valid && (!busy_reg || (advance && slot_reg == 2'd3));

    // pick the sextet for the current slot
    always_comb begin
        unique case (slot_reg)
            2'd0:    sext = group_reg.triple[23:18];
            2'd1:    sext = group_reg.triple[17:12];
            2'd2:    sext = group_reg.triple[11:6];
            default: sext = group_reg.triple[5:0];
        endcase
    end

    assign is_pad = ({1'b0, slot_reg} >= group_reg.n_chars);

    // slot sequencing and output stage
    always_comb begin
        group_next = group_reg;
        slot_next  = slot_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (advance) begin
            valid_next = 1'b1;
            char_next  = is_pad ? CharPad : b64e_char(sext);
            last_next  = group_reg.final_grp && (slot_reg == 2'd3);
            slot_next  = slot_reg + 2'd1;
            if (slot_reg == 2'd3) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
        if (q_pop) begin
            group_next = q_data;
            slot_next  = 2'd0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= 2'd0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        group_reg <= group_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign m_valid     = valid_reg;
    assign m_out_char  = char_reg;
    assign m_last_char = last_reg;

endmodule

`default_nettype wire

@@ src/base64_stream_encoder_top.sv @@
// Top level of the base64 stream encoder: front end, group queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
`default_nettype none

// Base64 (standard alphabet) encoder for a byte stream. One byte beat per
// cycle is taken while the two-entry group queue has room; each third byte,
// or the byte flagged last, closes a group. The back end emits one character
// per cycle while m_ready does not stall it, so this serializer sets the
// sustained throughput. A closing byte's group passes through a queue entry,
// the back end's group register and its output character register before
// its first character shows on m_*. Partial final groups are zero-filled and
// padded with '='; m_last_char marks the message's last character.
module base64_stream_encoder_top import b64e_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [ByteW-1:0] s_data_byte,
    input  wire logic             s_is_last,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [CharW-1:0]      m_out_char,
    output logic                  m_last_char
);

    logic   q_push, q_push_ready, q_pop, q_valid;
    group_t q_in, q_out;

    b64e_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_is_last   (s_is_last),
        .q_push      (q_push),
        .q_data      (q_in),
        .q_ready     (q_push_ready)
    );

    b64e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_data   (q_out),
        .pop_valid  (q_valid)
    );

    b64e_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

    // a group is never pushed into a full queue
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_push_ready)
        else $error("group pushed into full queue");

    // the back end only takes a group that is there
    a_pop_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // a padding character that does not end the message is followed by another
    a_pad_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_out_char == CharPad && !m_last_char)
        |=> (m_valid && m_out_char == CharPad))
        else $error("lone padding character mid-message");

endmodule

`default_nettype wire
